[src/csdi_pkg.sv]
// shared constants, widths and result codes for the clamped speed and distance integrator
// no dependencies
`default_nettype none

package csdi_pkg;

  localparam int SPEED_W  = 32;
  localparam int TIME_W   = 24;
  localparam int ACCEL_W  = 32;
  localparam int DIST_W   = 48;
  localparam int HIT_W    = 2;
  localparam int CFG_IDX_W = 1;

  // shared multiplier operand widths
  localparam int MUL_X_W  = 41;
  localparam int MUL_Y_W  = 25;
  localparam int MUL_P_W  = MUL_X_W + MUL_Y_W;

  // crossing-time divider
  localparam int DIV_N_W  = 57;
  localparam int DIV_D_W  = 40;
  localparam int DIV_Q_W  = TIME_W;

  localparam logic [HIT_W-1:0] LIMIT_NONE = 2'd0;
  localparam logic [HIT_W-1:0] LIMIT_MAX  = 2'd1;
  localparam logic [HIT_W-1:0] LIMIT_MIN  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 1'd1;

  localparam logic signed [SPEED_W-1:0] MAX_SPEED_RESET = 32'sd655360;
  localparam logic signed [SPEED_W-1:0] MIN_SPEED_RESET = 32'sd0;

endpackage

`default_nettype wire

[src/csdi_if.sv]
// handshake interfaces for step items, results and register writes
// depends on csdi_pkg
`default_nettype none

interface csdi_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  cmd;
  logic [csdi_pkg::TIME_W-1:0]           elapsed_time;
  logic signed [csdi_pkg::ACCEL_W-1:0]   accel;
  logic signed [csdi_pkg::SPEED_W-1:0]   speed_value;
  modport source (output valid, cmd, elapsed_time, accel, speed_value, input ready);
  modport sink   (input valid, cmd, elapsed_time, accel, speed_value, output ready);
endinterface

interface csdi_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [csdi_pkg::DIST_W-1:0]    distance;
  logic signed [csdi_pkg::SPEED_W-1:0]   new_speed;
  logic [csdi_pkg::HIT_W-1:0]            limit_hit;
  modport source (output valid, distance, new_speed, limit_hit, input ready);
  modport sink   (input valid, distance, new_speed, limit_hit, output ready);
endinterface

interface csdi_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [csdi_pkg::CFG_IDX_W-1:0]        index;
  logic [csdi_pkg::SPEED_W-1:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/csdi_div.sv]
// restoring divider, one quotient bit per cycle, quotient known to fit TIME_W bits
// depends on csdi_pkg
`default_nettype none

module csdi_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [csdi_pkg::DIV_N_W-1:0]     dividend,
  input  wire logic [csdi_pkg::DIV_D_W-1:0]     divisor,
  output logic                                  done,
  output logic [csdi_pkg::DIV_Q_W-1:0]          quotient
);

  localparam int CNT_W = $clog2(csdi_pkg::DIV_Q_W + 1);
  localparam int REM_W = csdi_pkg::DIV_D_W + 1;
  localparam int HI_W  = csdi_pkg::DIV_N_W - csdi_pkg::DIV_Q_W;

  logic [REM_W-1:0]              rem;
  logic [csdi_pkg::DIV_Q_W-1:0]  low_bits;
  logic [csdi_pkg::DIV_D_W-1:0]  den;
  logic [CNT_W-1:0]              cnt;
  logic                          busy;
  logic [REM_W-1:0]              trial;
  logic                          take;

  assign trial = {rem[REM_W-2:0], low_bits[csdi_pkg::DIV_Q_W-1]};
  assign take  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(csdi_pkg::DIV_Q_W);
        rem      <= REM_W'(dividend[csdi_pkg::DIV_N_W-1 -: HI_W]);
        low_bits <= dividend[csdi_pkg::DIV_Q_W-1:0];
        den      <= divisor;
      end else if (busy) begin
        rem      <= take ? trial - {1'b0, den} : trial;
        low_bits <= {low_bits[csdi_pkg::DIV_Q_W-2:0], 1'b0};
        quotient <= {quotient[csdi_pkg::DIV_Q_W-2:0], take};
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/clamped_speed_distance_integrator_top.sv]
// clamped speed and distance integrator, top level with sequencer and shared multiplier
// depends on csdi_pkg, csdi_if and csdi_div
// a load skips to the output stage; an advance runs the divider only when a limit is crossed
// the crossing-time divider and the single shared 41x25 multiplier set the step time
// one transaction in flight, next taken in the cycle after the result lands; a full output stalls
// synchronous reset: speed 0, max_speed 10.0, min_speed 0, no result pending
`default_nettype none

module clamped_speed_distance_integrator_top (
  input  wire logic       clk,
  input  wire logic       rst,
  csdi_in_if.sink         step_in,
  csdi_out_if.source      result_out,
  csdi_cfg_if.sink        cfg
);

  localparam int SW = csdi_pkg::SPEED_W;
  localparam int TW = csdi_pkg::TIME_W;
  localparam int XW = csdi_pkg::MUL_X_W;
  localparam int YW = csdi_pkg::MUL_Y_W;
  localparam int PW = csdi_pkg::MUL_P_W;
  localparam int DW = csdi_pkg::DIST_W;
  localparam int DVW = 40;
  localparam int FW = 41;
  localparam int TRW = 64;
  localparam int ACW = 72;

  typedef enum logic [3:0] {
    S_IDLE, S_DV, S_FIN, S_DECIDE, S_NUM, S_DIVGO, S_DIV, S_DS, S_DSR, S_DSS,
    S_VS, S_TAIL, S_ACC, S_SC1, S_SC2, S_SC3
  } state_t;

  state_t state;

  logic signed [SW-1:0]   max_speed, min_speed, current_speed;
  logic [TW-1:0]          t_r, s_r;
  logic signed [SW-1:0]   a_r, v_r, lim_r;
  logic signed [FW-1:0]   fin_r;
  logic [SW:0]            num_r;
  logic [DVW-1:0]         den_r;
  logic signed [DVW-1:0]  ds_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [TRW-1:0]  travel;
  logic signed [ACW-1:0]  acc;
  logic signed [SW-1:0]   res_speed;
  logic [csdi_pkg::HIT_W-1:0] res_hit;
  logic                   out_valid;
  logic signed [DW-1:0]   out_dist;
  logic signed [SW-1:0]   out_speed;
  logic [csdi_pkg::HIT_W-1:0] out_hit;

  logic signed [XW-1:0]   mul_x;
  logic signed [YW-1:0]   mul_y;
  logic signed [PW-1:0]   mul_p;

  logic                   div_start, div_done;
  logic [csdi_pkg::DIV_Q_W-1:0] div_q;

  logic signed [FW-1:0]   max_w, min_w, v_w;
  logic                   hit_max, hit_min;
  logic signed [ACW-16-1:0] scaled;
  logic                   out_free;

  assign step_in.ready = (state == S_IDLE);
  assign cfg.ready     = 1'b1;
  assign result_out.valid     = out_valid;
  assign result_out.distance  = out_dist;
  assign result_out.new_speed = out_speed;
  assign result_out.limit_hit = out_hit;
  assign out_free = !out_valid || result_out.ready;

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state)
      S_DV: begin
        mul_x = XW'(a_r);
        mul_y = $signed({1'b0, t_r});
      end
      S_NUM: begin
        mul_x = $signed(XW'(num_r));
        mul_y = $signed({1'b0, t_r});
      end
      S_DS: begin
        mul_x = XW'(a_r);
        mul_y = $signed({1'b0, s_r});
      end
      S_DSS: begin
        mul_x = XW'(ds_r);
        mul_y = $signed({1'b0, s_r});
      end
      S_VS: begin
        mul_x = XW'(v_r);
        mul_y = $signed({1'b0, s_r});
      end
      S_TAIL: begin
        mul_x = XW'(lim_r);
        mul_y = $signed({1'b0, t_r - s_r});
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  assign max_w   = FW'(max_speed);
  assign min_w   = FW'(min_speed);
  assign v_w     = FW'(v_r);
  assign hit_max = (fin_r > max_w) && (v_w <= max_w);
  assign hit_min = (fin_r < min_w) && (v_w >= min_w);
  assign scaled  = acc[ACW-1:16];
  assign div_start = (state == S_DIVGO);

  csdi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_r[csdi_pkg::DIV_N_W-1:0]),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      max_speed     <= csdi_pkg::MAX_SPEED_RESET;
      min_speed     <= csdi_pkg::MIN_SPEED_RESET;
      current_speed <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (state == S_SC3 && out_free) out_valid <= 1'b1;
      else if (result_out.ready) out_valid <= 1'b0;
      if (cfg.valid) begin
        case (cfg.index)
          csdi_pkg::REG_MAX_SPEED: max_speed <= $signed(cfg.data);
          csdi_pkg::REG_MIN_SPEED: min_speed <= $signed(cfg.data);
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (step_in.valid) begin
            t_r <= step_in.elapsed_time;
            a_r <= step_in.accel;
            v_r <= current_speed;
            if (step_in.cmd) begin
              acc       <= '0;
              res_speed <= step_in.speed_value;
              res_hit   <= csdi_pkg::LIMIT_NONE;
              state     <= S_SC3;
            end else begin
              state <= S_DV;
            end
          end
        end
        S_DV: begin
          prod_r <= mul_p;
          state  <= S_FIN;
        end
        S_FIN: begin
          fin_r <= v_w + FW'($signed(prod_r[55:16]));
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (hit_max) begin
            lim_r     <= max_speed;
            num_r     <= (SW+1)'(max_w - v_w);
            den_r     <= DVW'(fin_r - v_w);
            res_speed <= max_speed;
            res_hit   <= csdi_pkg::LIMIT_MAX;
            state     <= S_NUM;
          end else if (hit_min) begin
            lim_r     <= min_speed;
            num_r     <= (SW+1)'(v_w - min_w);
            den_r     <= DVW'(v_w - fin_r);
            res_speed <= min_speed;
            res_hit   <= csdi_pkg::LIMIT_MIN;
            state     <= S_NUM;
          end else begin
            lim_r   <= '0;
            s_r     <= t_r;
            res_hit <= csdi_pkg::LIMIT_NONE;
            if (fin_r > FW'(32'sh7fffffff))
              res_speed <= 32'sh7fffffff;
            else if (fin_r < FW'(32'sh80000000))
              res_speed <= 32'sh80000000;
            else
              res_speed <= fin_r[SW-1:0];
            state <= S_DS;
          end
        end
        S_NUM: begin
          prod_r <= mul_p;
          state  <= S_DIVGO;
        end
        S_DIVGO: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            s_r   <= div_q;
            state <= S_DS;
          end
        end
        S_DS: begin
          prod_r <= mul_p;
          state  <= S_DSR;
        end
        S_DSR: begin
          ds_r  <= prod_r[55:16];
          state <= S_DSS;
        end
        S_DSS: begin
          prod_r <= mul_p;
          state  <= S_VS;
        end
        S_VS: begin
          travel <= prod_r[TRW:1];
          prod_r <= mul_p;
          state  <= S_TAIL;
        end
        S_TAIL: begin
          travel <= travel + prod_r[TRW-1:0];
          prod_r <= mul_p;
          state  <= S_ACC;
        end
        S_ACC: begin
          travel <= travel + prod_r[TRW-1:0];
          state  <= S_SC1;
        end
        S_SC1: begin
          acc   <= (ACW'(travel) <<< 6) + (ACW'(travel) <<< 5);
          state <= S_SC2;
        end
        S_SC2: begin
          acc   <= acc + (ACW'(travel) <<< 2);
          state <= S_SC3;
        end
        S_SC3: begin
          if (out_free) begin
            out_speed     <= res_speed;
            out_hit       <= res_hit;
            current_speed <= res_speed;
            state         <= S_IDLE;
            if (scaled > (ACW-16)'(48'sh7fffffffffff))
              out_dist <= 48'sh7fffffffffff;
            else if (scaled < (ACW-16)'(48'sh800000000000))
              out_dist <= 48'sh800000000000;
            else
              out_dist <= scaled[DW-1:0];
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
